[rtl/core/ffha_pkg.sv]
// Package of shared types and constants for the first-fit heap allocator.
package ffha_pkg;
   localparam int POOL_BYTES_DEF = 4096;
   localparam int HEADER_BYTES   = 2;
   localparam int HDR_W          = 16;
   localparam int SIZE_W         = 12;
   localparam int STATUS_W       = 3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd4;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_INIT_HEAD, S_INIT_END, S_IDLE, S_READ, S_CHECK,
      S_NEXT_READ, S_NEXT_CHECK, S_WRITE, S_RESP
   } state_type;
endpackage

[rtl/core/ffha_mem.sv]
// Header word memory: one write port and one registered read port.
module ffha_mem
   import ffha_pkg::*;
#(
   parameter int DEPTH = POOL_BYTES_DEF / 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [HDR_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [HDR_W-1:0]         rd_data
);
   logic [HDR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/first_fit_heap_allocator_core.sv]
// Top level of the first-fit heap allocator: header walk sequencer and result register.
//
//   Channel   Dir   Beat contents
//   req_*     in    tuser: action; tdata: request_size [11:0], block_address [23:12]
//   rsp_*     out   tdata: status [2:0], granted_address [14:3]
//
// One request occupies the block from acceptance until its response beat is taken.
// The header walk visits each block header through S_READ and S_CHECK, because
// each step goes through the registered read port of the single header memory; a
// free adds the neighbour read in S_NEXT_READ and S_NEXT_CHECK, and up to three
// header writes follow at one a cycle in S_WRITE, then the response beat in S_RESP.
// After reset the init states write the initial free block and the end marker; the
// block then becomes ready. Words inside payloads are never read, so no clearing
// pass is needed. A stalled response simply holds the block in its response state.
module first_fit_heap_allocator_core
   import ffha_pkg::*;
#(
   parameter int POOL_BYTES = POOL_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   input  logic [23:0] req_tdata,   // request_size, block_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status, granted_address, zero fill
);
   localparam int WORDS = POOL_BYTES / 2;
   localparam int IDX_W = $clog2(WORDS);
   // Arithmetic width: holds offset plus header plus size without overflow.
   localparam int AW = ($clog2(POOL_BYTES) + 2 > 17) ? $clog2(POOL_BYTES) + 2 : 17;
   localparam logic [AW-1:0] END_OFF = AW'(POOL_BYTES - HEADER_BYTES);
   localparam logic [AW-1:0] HDR_SZ  = AW'(HEADER_BYTES);
   localparam logic [AW-1:0] MIN_REST = AW'(HEADER_BYTES + 2);

   state_type         state_ff, state_in;
   logic              action_ff, action_in;
   logic [AW-1:0]     need_ff, need_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     off_ff, off_in;
   logic [AW-1:0]     sz_ff, sz_in;
   logic [AW-1:0]     prev_off_ff, prev_off_in;
   logic [HDR_W-1:0]  prev_hdr_ff, prev_hdr_in;
   logic              have_prev_ff, have_prev_in;
   logic [AW-1:0]     nxt_ff, nxt_in;
   logic [AW-1:0]     wr_off_ff [3];
   logic [AW-1:0]     wr_off_in [3];
   logic [HDR_W-1:0]  wr_val_ff [3];
   logic [HDR_W-1:0]  wr_val_in [3];
   logic [1:0]        wr_num_ff, wr_num_in;
   logic [1:0]        wr_idx_ff, wr_idx_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SIZE_W-1:0] grant_ff, grant_in;

   logic              mem_we;
   logic [AW-1:0]     mem_woff;
   logic [HDR_W-1:0]  mem_wdata;
   logic [AW-1:0]     mem_roff;
   logic [HDR_W-1:0]  mem_rdata;

   logic [AW-1:0]     h_ext, h_sz, blk_end, psz;
   logic              blk_ok;

   ffha_mem #(.DEPTH(WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_woff[IDX_W:1]),
      .wr_data (mem_wdata),
      .rd_addr (mem_roff[IDX_W:1]),
      .rd_data (mem_rdata)
   );

   // Decode of the header word just read, relative to the offset it came from.
   always_comb begin
      h_ext   = AW'(mem_rdata);
      h_sz    = h_ext & ~AW'(1);
      blk_end = ((state_ff == S_NEXT_CHECK) ? nxt_ff : off_ff) + HDR_SZ + h_sz;
      blk_ok  = (h_sz != '0) && (blk_end <= END_OFF);
      psz     = AW'(prev_hdr_ff) & ~AW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      need_in      = need_ff;
      addr_in      = addr_ff;
      off_in       = off_ff;
      sz_in        = sz_ff;
      prev_off_in  = prev_off_ff;
      prev_hdr_in  = prev_hdr_ff;
      have_prev_in = have_prev_ff;
      nxt_in       = nxt_ff;
      wr_off_in    = wr_off_ff;
      wr_val_in    = wr_val_ff;
      wr_num_in    = wr_num_ff;
      wr_idx_in    = wr_idx_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      mem_we       = 1'b0;
      mem_woff     = wr_off_ff[wr_idx_ff];
      mem_wdata    = wr_val_ff[wr_idx_ff];
      mem_roff     = (state_ff == S_NEXT_READ) ? nxt_ff : off_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;

      case (state_ff)
         S_INIT_HEAD: begin
            mem_we    = 1'b1;
            mem_woff  = '0;
            mem_wdata = HDR_W'(POOL_BYTES - 4);
            state_in  = S_INIT_END;
         end
         S_INIT_END: begin
            mem_we    = 1'b1;
            mem_woff  = END_OFF;
            mem_wdata = HDR_W'(1);
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               action_in    = req_tuser;
               // Round up to even; a zero request keeps need at zero.
               need_in      = (AW'(req_tdata[11:0]) + AW'(1)) & ~AW'(1);
               addr_in      = AW'(req_tdata[23:12]);
               off_in       = '0;
               have_prev_in = 1'b0;
               status_in    = ST_OK;
               grant_in     = '0;
               wr_idx_in    = '0;
               if (req_tuser == ACT_ALLOC && req_tdata[11:0] == '0) begin
                  status_in = ST_ZERO_SIZE;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            sz_in = h_sz;
            if (action_ff == ACT_ALLOC) begin
               if (!blk_ok) begin
                  status_in = ST_EXHAUSTED;
                  state_in  = S_RESP;
               end else if (!mem_rdata[0] && h_sz >= need_ff) begin
                  grant_in = SIZE_W'(off_ff + HDR_SZ);
                  if (h_sz - need_ff >= MIN_REST) begin
                     wr_off_in[0] = off_ff;
                     wr_val_in[0] = HDR_W'(need_ff | AW'(1));
                     wr_off_in[1] = off_ff + HDR_SZ + need_ff;
                     wr_val_in[1] = HDR_W'(h_sz - need_ff - HDR_SZ);
                     wr_num_in    = 2'd2;
                  end else begin
                     wr_off_in[0] = off_ff;
                     wr_val_in[0] = HDR_W'(h_sz | AW'(1));
                     wr_num_in    = 2'd1;
                  end
                  state_in = S_WRITE;
               end else begin
                  off_in = blk_end;
                  if (blk_end >= END_OFF) begin
                     status_in = ST_EXHAUSTED;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end else begin
               if (!blk_ok) begin
                  status_in = ST_BAD_ADDR;
                  state_in  = S_RESP;
               end else if (off_ff + HDR_SZ == addr_ff) begin
                  if (!mem_rdata[0]) begin
                     status_in = ST_DBL_FREE;
                     state_in  = S_RESP;
                  end else begin
                     nxt_in   = blk_end;
                     state_in = S_NEXT_READ;
                  end
               end else if (off_ff + HDR_SZ > addr_ff) begin
                  status_in = ST_BAD_ADDR;
                  state_in  = S_RESP;
               end else begin
                  prev_off_in  = off_ff;
                  prev_hdr_in  = mem_rdata;
                  have_prev_in = 1'b1;
                  off_in       = blk_end;
                  if (blk_end >= END_OFF) begin
                     status_in = ST_BAD_ADDR;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_NEXT_READ: begin
            state_in = S_NEXT_CHECK;
         end
         S_NEXT_CHECK: begin
            // Build the write list: absorb a free successor, then merge backwards.
            if (blk_ok && !mem_rdata[0]) begin
               wr_off_in[0] = nxt_ff;
               wr_val_in[0] = '0;
               if (have_prev_ff && !prev_hdr_ff[0]) begin
                  wr_off_in[1] = prev_off_ff;
                  wr_val_in[1] = HDR_W'(psz + HDR_SZ + sz_ff + HDR_SZ + h_sz);
                  wr_off_in[2] = off_ff;
                  wr_val_in[2] = '0;
                  wr_num_in    = 2'd3;
               end else begin
                  wr_off_in[1] = off_ff;
                  wr_val_in[1] = HDR_W'(sz_ff + HDR_SZ + h_sz);
                  wr_num_in    = 2'd2;
               end
            end else if (have_prev_ff && !prev_hdr_ff[0]) begin
               wr_off_in[0] = prev_off_ff;
               wr_val_in[0] = HDR_W'(psz + HDR_SZ + sz_ff);
               wr_off_in[1] = off_ff;
               wr_val_in[1] = '0;
               wr_num_in    = 2'd2;
            end else begin
               wr_off_in[0] = off_ff;
               wr_val_in[0] = HDR_W'(sz_ff);
               wr_num_in    = 2'd1;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we = 1'b1;
            if (wr_idx_ff + 2'd1 == wr_num_ff) begin
               state_in = S_RESP;
            end else begin
               wr_idx_in = wr_idx_ff + 2'd1;
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_HEAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      need_ff      <= need_in;
      addr_ff      <= addr_in;
      off_ff       <= off_in;
      sz_ff        <= sz_in;
      prev_off_ff  <= prev_off_in;
      prev_hdr_ff  <= prev_hdr_in;
      have_prev_ff <= have_prev_in;
      nxt_ff       <= nxt_in;
      wr_off_ff    <= wr_off_in;
      wr_val_ff    <= wr_val_in;
      wr_num_ff    <= wr_num_in;
      wr_idx_ff    <= wr_idx_in;
      status_ff    <= status_in;
      grant_ff     <= grant_in;
   end

   assign rsp_tdata = {1'b0, grant_ff, status_ff};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request taken while a response is pending");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff != ST_OK |-> grant_ff == '0)
      else $error("address granted with a failing status");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mem_we)
      else $error("header write while idle");

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
endmodule
